// ===== hw/rtl/lge_pkg.sv =====
// Shared types and constants of the life grid generation engine.
// Used by lge_row_cell and life_grid_generation_engine; depends on nothing.
package lge_pkg;

	// Width of the row and column fields of an input item.
	localparam int COORD_W = 6;

	// Action codes carried by an input item.
	typedef enum logic [1:0] {
		ACT_SET     = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	// Control shared by every row cell of the chain.
	typedef struct packed {
		logic clear;   // zero the row
		logic shift;   // take the row handed on by the next cell
		logic set_en;  // write one cell of the row if the row is hit
		logic set_val; // value written by a set
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/lge_row_cell.sv =====
// One cell of the row chain: holds one grid row and hands it to its neighbor on a shift.
// Depends on lge_pkg for the control struct.
module lge_row_cell #(
	parameter int WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lge_pkg::cell_ctrl_t ctrl,
	input  logic               row_hit,
	input  logic [WIDTH-1:0]   col_mask,
	input  logic [WIDTH-1:0]   shift_in,
	output logic [WIDTH-1:0]   row_q,
	output logic               read_bit
);

	// Row storage: clear, shift along the chain, or write one cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.clear) begin
			row_q <= '0;
		end else if (ctrl.shift) begin
			row_q <= shift_in;
		end else if (ctrl.set_en && row_hit) begin
			row_q <= ctrl.set_val ? (row_q | col_mask) : (row_q & ~col_mask);
		end
	end

	// The addressed cell, seen only when this row is hit.
	assign read_bit = row_hit & (|(row_q & col_mask));

endmodule

// ===== hw/rtl/lge_rule_unit.sv =====
// Next-generation logic for one row under the B3/S23 rule, from the rows above and below.
// Depends on nothing; cells beyond the row ends count as dead.
module lge_rule_unit #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] above,
	input  logic [WIDTH-1:0] cur,
	input  logic [WIDTH-1:0] below,
	output logic [WIDTH-1:0] next_row
);

	logic [WIDTH+1:0] above_x;
	logic [WIDTH+1:0] cur_x;
	logic [WIDTH+1:0] below_x;

	// Pad each row with a dead cell at both ends.
	assign above_x = {1'b0, above, 1'b0};
	assign cur_x   = {1'b0, cur, 1'b0};
	assign below_x = {1'b0, below, 1'b0};

	// Count the eight neighbors of every column and apply the rule.
	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < WIDTH; c++) begin
			n = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2])
			  + 4'(cur_x[c]) + 4'(cur_x[c+2])
			  + 4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
			next_row[c] = (n == 4'd3) | ((n == 4'd2) & cur[c]);
		end
	end

endmodule

// ===== hw/rtl/life_grid_generation_engine.sv =====
// Top level of the life grid generation engine: command handling, sweep control, row chain.
// Depends on lge_pkg, lge_row_cell and lge_rule_unit.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------
//  input   | start high, busy low    | action, row, col, cell_value
//  result  | done high for one cycle | read_value
//
// For set cell, read cell and clear grid, done follows in the cycle after the command is taken.
// Advance generation rotates the rows once through the cell chain, one row a cycle
// through the rule unit at its head; done follows the last row.
// Reset clears every cell at once. The receiver cannot stall; busy is high during a sweep.
module life_grid_generation_engine #(
	parameter int GRID_SIZE = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [lge_pkg::COORD_W-1:0] row,
	input  logic [lge_pkg::COORD_W-1:0] col,
	input  logic                       cell_value,
	output logic                       done,
	output logic                       read_value
);

	localparam int SIZE_W = $clog2(GRID_SIZE + 1);
	localparam int CMP_W  = (lge_pkg::COORD_W > SIZE_W) ? lge_pkg::COORD_W : SIZE_W;
	localparam int CNT_W  = $clog2(GRID_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [GRID_SIZE-1:0]   prev_q;
	logic                   done_q;
	logic                   read_value_q;

	logic                   accept;
	logic                   in_grid;
	logic                   last_row;
	logic [CMP_W-1:0]       row_x;
	logic [CMP_W-1:0]       col_x;
	logic [GRID_SIZE-1:0]   row_mask;
	logic [GRID_SIZE-1:0]   col_mask;
	logic [GRID_SIZE-1:0]   read_bits;
	logic [GRID_SIZE-1:0]   rows [GRID_SIZE];
	logic [GRID_SIZE-1:0]   below_row;
	logic [GRID_SIZE-1:0]   new_row;
	lge_pkg::cell_ctrl_t    ctrl;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign row_x    = CMP_W'(row);
	assign col_x    = CMP_W'(col);
	assign in_grid  = (row_x < CMP_W'(GRID_SIZE)) && (col_x < CMP_W'(GRID_SIZE));
	assign last_row = (cnt_q == CNT_W'(GRID_SIZE - 1));

	// One-hot decode of the addressed row and column.
	always_comb begin
		for (int i = 0; i < GRID_SIZE; i++) begin
			row_mask[i] = (row_x == CMP_W'(i));
			col_mask[i] = (col_x == CMP_W'(i));
		end
	end

	// Control for the row chain.
	always_comb begin
		ctrl.clear   = accept && (lge_pkg::action_t'(action) == lge_pkg::ACT_CLEAR);
		ctrl.shift   = (state_q == ST_SWEEP);
		ctrl.set_en  = accept && (lge_pkg::action_t'(action) == lge_pkg::ACT_SET) && in_grid;
		ctrl.set_val = cell_value;
	end

	// Row chain: the head row leaves for the rule unit, the new row enters at the tail.
	for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
		logic [GRID_SIZE-1:0] shift_in;
		if (i == GRID_SIZE - 1) begin : g_tail
			assign shift_in = new_row;
		end else begin : g_body
			assign shift_in = rows[i+1];
		end
		lge_row_cell #(
			.WIDTH (GRID_SIZE)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.row_hit  (row_mask[i]),
			.col_mask (col_mask),
			.shift_in (shift_in),
			.row_q    (rows[i]),
			.read_bit (read_bits[i])
		);
	end

	// On the last row the next cell already holds the new first row, so below is dead.
	assign below_row = last_row ? '0 : rows[1];

	lge_rule_unit #(
		.WIDTH (GRID_SIZE)
	) u_rule (
		.above    (prev_q),
		.cur      (rows[0]),
		.below    (below_row),
		.next_row (new_row)
	);

	// Sweep sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			prev_q       <= '0;
			done_q       <= 1'b0;
			read_value_q <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			read_value_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (lge_pkg::action_t'(action) == lge_pkg::ACT_ADVANCE) begin
							state_q <= ST_SWEEP;
							cnt_q   <= '0;
							prev_q  <= '0;
						end else begin
							done_q <= 1'b1;
							if (lge_pkg::action_t'(action) == lge_pkg::ACT_READ) begin
								read_value_q <= |read_bits;
							end
						end
					end
				end
				ST_SWEEP: begin
					prev_q <= rows[0];
					cnt_q  <= cnt_q + 1'b1;
					if (last_row) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;

endmodule
